// ----- hdl/asr_pkg.sv -----
// Package for the ADC sample scaling ring block.
// Holds field widths, ring geometry, result and request codes and register indexes.
// No dependencies; compiled first.
package asr_pkg;

  localparam int RingDepth  = 32;
  localparam int Channels   = 4;
  localparam int MaxResults = 32;

  localparam int ChanW    = 2;
  localparam int RawW     = 12;
  localparam int CntW     = 7;
  localparam int PosW     = 6;
  localparam int KindW    = 2;
  localparam int ValW     = 32;
  localparam int CoefW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int ActW     = 3;
  localparam int AbsW     = 4;

  localparam int PtrW  = $clog2(RingDepth);
  localparam int FillW = $clog2(RingDepth + 1);
  localparam int MemAw = ChanW + PtrW;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqRead   = 1'b1;

  localparam logic [KindW-1:0] KindEcho  = 2'd0;
  localparam logic [KindW-1:0] KindRing  = 2'd1;
  localparam logic [KindW-1:0] KindEmpty = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgGain   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAbs    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgActive = 2'd3;

  localparam logic [ActW-1:0] ActiveReset = 3'd4;

endpackage

// ----- hdl/asr_if.sv -----
// Valid/ready channel interfaces for the sample scaling ring block.
// Depends on asr_pkg for field widths.
interface asr_in_if;
  import asr_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ChanW-1:0] channel;
  logic [RawW-1:0]  raw_sample;
  logic [CntW-1:0]  max_items;

  modport source (output valid, req_type, channel, raw_sample, max_items, input ready);
  modport sink   (input valid, req_type, channel, raw_sample, max_items, output ready);
endinterface

interface asr_out_if;
  import asr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  logic [ChanW-1:0]       chan_out;
  logic [RawW-1:0]        raw_out;
  logic signed [ValW-1:0] ring_value;
  logic signed [ValW-1:0] latest_scaled;
  logic [PosW-1:0]        position;
  logic [CntW-1:0]        returned_count;
  logic                   last;

  modport source (output valid, kind, chan_out, raw_out, ring_value, latest_scaled,
                  position, returned_count, last, input ready);
  modport sink   (input valid, kind, chan_out, raw_out, ring_value, latest_scaled,
                  position, returned_count, last, output ready);
endinterface

// ----- hdl/asr_ring.sv -----
// Ring storage for all channels: one write port, one registered read port.
// Depends on asr_pkg for address and data widths.
module asr_ring (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [asr_pkg::MemAw-1:0]      waddr_i,
  input  logic signed [asr_pkg::ValW-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [asr_pkg::MemAw-1:0]      raddr_i,
  output logic signed [asr_pkg::ValW-1:0] rdata_o
);
  import asr_pkg::*;

  logic signed [ValW-1:0] mem_q [2**MemAw];
  logic signed [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/asr_scale.sv -----
// Sample scaling unit: one shared signed multiplier used twice per sample,
// first for raw*33*gain, then for the reciprocal divide by five. Depends on asr_pkg.
module asr_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [asr_pkg::RawW-1:0]         raw_i,
  input  logic signed [asr_pkg::CoefW-1:0] gain_i,
  input  logic signed [asr_pkg::CoefW-1:0] offset_i,
  input  logic                             abs_i,
  output logic                             done_o,
  output logic signed [asr_pkg::ValW-1:0]  value_o
);
  import asr_pkg::*;

  localparam int OpW   = 29;
  localparam int ProdW = 2 * OpW;
  localparam int P1W   = 36;   // raw*33*gain plus rounding, with headroom
  localparam int YW    = 28;
  localparam int QW    = 27;
  localparam int VW    = 28;
  localparam int RoundShift = 9;
  localparam int RecipShift = 30;
  localparam logic signed [P1W-1:0] RoundAdd = 36'sd1280;
  // x + 5*2^24 keeps the dividend positive; floor((x+5B)/5) = floor(x/5) + B
  localparam logic signed [YW-1:0]  DivBias  = 28'sd83886080;
  localparam logic signed [VW-1:0]  QuoBias  = 28'sd16777216;
  localparam logic signed [OpW-1:0] RecipM   = 29'sd214748364;   // floor(2^30/5)
  localparam logic [OpW-1:0]        Five     = 29'd5;

  typedef enum logic [2:0] {
    SC_IDLE, SC_MUL_GAIN, SC_BIAS, SC_MUL_RECIP, SC_FIX
  } sc_state_e;

  sc_state_e               state_q;
  logic signed [OpW-1:0]   op_a_q, op_b_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [CoefW-1:0] offset_q;
  logic                    abs_q;
  logic                    done_q;
  logic signed [ValW-1:0]  value_q;

  logic [OpW-1:0]          raw33;
  logic signed [ProdW-1:0] prod_d;
  logic signed [P1W-1:0]   rnd;
  logic signed [YW-1:0]    y_d;
  logic [QW-1:0]           q0, q_fix;
  logic [OpW-1:0]          five_q0, rem;
  logic signed [VW-1:0]    v, v_abs;

  assign raw33  = (OpW'(raw_i) << 5) + OpW'(raw_i);
  // the shared multiplier
  assign prod_d = ProdW'(op_a_q) * ProdW'(op_b_q);

  always_comb begin
    rnd = P1W'($signed(prod_q[P1W-2:0])) + RoundAdd;
    y_d = YW'($signed(rnd[P1W-1:RoundShift])) + DivBias;
  end

  // quotient estimate is exact or one low; one compare fixes it
  always_comb begin
    q0      = prod_q[RecipShift +: QW];
    five_q0 = (OpW'(q0) << 2) + OpW'(q0);
    rem     = OpW'(op_a_q[YW-2:0]) - five_q0;
    q_fix   = q0 + QW'(rem >= Five);
    v       = $signed({1'b0, q_fix}) - QuoBias + (VW'(offset_q) <<< 8);
    v_abs   = (abs_q && v < 0) ? -v : v;
  end

  // |v| stays below 2^26, so the 32-bit clamp never engages; sign-extend only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SC_IDLE;
      op_a_q   <= '0;
      op_b_q   <= '0;
      prod_q   <= '0;
      offset_q <= '0;
      abs_q    <= 1'b0;
      done_q   <= 1'b0;
      value_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            op_a_q   <= $signed(raw33);
            op_b_q   <= OpW'(gain_i);
            offset_q <= offset_i;
            abs_q    <= abs_i;
            state_q  <= SC_MUL_GAIN;
          end
        end
        SC_MUL_GAIN: begin
          prod_q  <= prod_d;
          state_q <= SC_BIAS;
        end
        SC_BIAS: begin
          op_a_q  <= OpW'(y_d);
          op_b_q  <= RecipM;
          state_q <= SC_MUL_RECIP;
        end
        SC_MUL_RECIP: begin
          prod_q  <= prod_d;
          state_q <= SC_FIX;
        end
        SC_FIX: begin
          value_q <= ValW'(v_abs);
          done_q  <= 1'b1;
          state_q <= SC_IDLE;
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

// ----- hdl/adc_sample_scale_ring.sv -----
// Top level: per-channel sample scaling with a newest-first ring of scaled values.
// Depends on asr_pkg, asr_if, asr_scale and asr_ring.
//
//   port        dir  transfer contents
//   in_i        in   req_type, channel, raw_sample, max_items
//   out_o       out  kind, chan_out, raw_out, ring_value, latest_scaled,
//                    position, returned_count, last
//   cfg_*_i     in   gain_words, offset_words, abs_mask, active_channels
//
// A sample goes from transfer to echo through the four steps of the shared
// multiplier in asr_scale, then ST_PUSH. A read gives its ring values one at
// a time (ring read, then registered read data to the output). in_i.ready is
// high only while idle. Stalls on out_o hold the sequencer. Reset clears the
// pointers, fill counts, latest values and the configuration, bar active_q,
// which resets to ActiveReset; ring entries are only read once written.
module adc_sample_scale_ring (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [asr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [asr_pkg::CfgDataW-1:0]   cfg_data_i,
  asr_in_if.sink                         in_i,
  asr_out_if.source                      out_o
);
  import asr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_PUSH, ST_EMPTY, ST_FETCH, ST_RING
  } state_e;

  state_e                  state_q;
  logic [CfgDataW-1:0]     gain_q, offset_q;
  logic [AbsW-1:0]         abs_mask_q;
  logic [ActW-1:0]         active_q;

  logic [PtrW-1:0]         wp_q      [Channels];
  logic [FillW-1:0]        fill_q    [Channels];
  logic [RawW-1:0]         lat_raw_q [Channels];
  logic signed [ValW-1:0]  lat_val_q [Channels];

  logic [ChanW-1:0]        ch_q;
  logic [RawW-1:0]         raw_q;
  logic [CntW-1:0]         n_q, idx_q;
  logic [RawW-1:0]         rd_raw_q;
  logic signed [ValW-1:0]  rd_lat_q;

  logic                    out_valid_q;
  logic [KindW-1:0]        out_kind_q;
  logic [ChanW-1:0]        out_chan_q;
  logic [RawW-1:0]         out_raw_q;
  logic signed [ValW-1:0]  out_ring_q, out_lat_q;
  logic [PosW-1:0]         out_pos_q;
  logic [CntW-1:0]         out_cnt_q;
  logic                    out_last_q;

  logic [ActW-1:0]         act_lim;
  logic                    in_active, in_fire, out_free, out_load, sc_start, sc_done;
  logic signed [ValW-1:0]  sc_value, mem_rdata;
  logic [CntW-1:0]         in_fill, n_min, n_cand;
  logic [PtrW+1:0]         rd_tmp;
  logic [PtrW-1:0]         rd_ptr;
  logic [PtrW:0]           wp_inc;
  logic [PtrW-1:0]         wp_next;
  logic                    mem_we, mem_re;
  logic                    ring_last;

  // channel gating and read length
  always_comb begin
    act_lim   = (active_q > ActW'(Channels)) ? ActW'(Channels) : active_q;
    in_active = {1'b0, in_i.channel} < act_lim;
    in_fill   = CntW'(fill_q[in_i.channel]);
    n_min     = (in_fill < in_i.max_items) ? in_fill : in_i.max_items;
    n_cand    = (n_min > CntW'(MaxResults)) ? CntW'(MaxResults) : n_min;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign sc_start   = in_fire && (in_i.req_type == ReqSample) && in_active;
  assign out_free   = !out_valid_q || out_o.ready;
  // a new result enters the output register this cycle
  assign out_load   = out_free &&
                      (state_q == ST_PUSH || state_q == ST_EMPTY || state_q == ST_RING);

  // newest-first ring walk: index wp-1-i modulo the ring depth
  always_comb begin
    rd_tmp = (PtrW+2)'(wp_q[ch_q]) + (PtrW+2)'(RingDepth - 1) - (PtrW+2)'(idx_q);
    rd_ptr = (rd_tmp >= (PtrW+2)'(RingDepth)) ? PtrW'(rd_tmp - (PtrW+2)'(RingDepth))
                                              : PtrW'(rd_tmp);
    wp_inc  = (PtrW+1)'(wp_q[ch_q]) + 1'b1;
    wp_next = (wp_inc >= (PtrW+1)'(RingDepth)) ? '0 : PtrW'(wp_inc);
  end

  assign mem_we    = (state_q == ST_PUSH) && out_free;
  assign mem_re    = (state_q == ST_FETCH);
  assign ring_last = (idx_q + 1'b1) == n_q;

  asr_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start),
    .raw_i    (in_i.raw_sample),
    .gain_i   ($signed(gain_q[CoefW*in_i.channel +: CoefW])),
    .offset_i ($signed(offset_q[CoefW*in_i.channel +: CoefW])),
    .abs_i    (abs_mask_q[in_i.channel]),
    .done_o   (sc_done),
    .value_o  (sc_value)
  );

  asr_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({ch_q, wp_q[ch_q]}),
    .wdata_i (sc_value),
    .re_i    (mem_re),
    .raddr_i ({ch_q, rd_ptr}),
    .rdata_o (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= '0;
      offset_q   <= '0;
      abs_mask_q <= '0;
      active_q   <= ActiveReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGain:   gain_q     <= cfg_data_i;
        CfgOffset: offset_q   <= cfg_data_i;
        CfgAbs:    abs_mask_q <= cfg_data_i[AbsW-1:0];
        CfgActive: active_q   <= cfg_data_i[ActW-1:0];
        default:   active_q   <= active_q;
      endcase
    end
  end

  // sequencer, channel state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      raw_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      rd_raw_q    <= '0;
      rd_lat_q    <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KindEcho;
      out_chan_q  <= '0;
      out_raw_q   <= '0;
      out_ring_q  <= '0;
      out_lat_q   <= '0;
      out_pos_q   <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
      for (int c = 0; c < Channels; c++) begin
        wp_q[c]      <= '0;
        fill_q[c]    <= '0;
        lat_raw_q[c] <= '0;
        lat_val_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ch_q     <= in_i.channel;
            raw_q    <= in_i.raw_sample;
            n_q      <= n_cand;
            idx_q    <= '0;
            rd_raw_q <= in_active ? lat_raw_q[in_i.channel] : '0;
            rd_lat_q <= in_active ? lat_val_q[in_i.channel] : '0;
            if (in_i.req_type == ReqSample) begin
              // drop samples for channels not in use
              if (in_active) begin
                state_q <= ST_SCALE;
              end
            end else if (!in_active || n_cand == '0) begin
              state_q <= ST_EMPTY;
            end else begin
              state_q <= ST_FETCH;
            end
          end
        end
        ST_SCALE: begin
          if (sc_done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_kind_q      <= KindEcho;
            out_chan_q      <= ch_q;
            out_raw_q       <= raw_q;
            out_ring_q      <= sc_value;
            out_lat_q       <= sc_value;
            out_pos_q       <= '0;
            out_cnt_q       <= '0;
            out_last_q      <= 1'b1;
            lat_raw_q[ch_q] <= raw_q;
            lat_val_q[ch_q] <= sc_value;
            wp_q[ch_q]      <= wp_next;
            if (fill_q[ch_q] < FillW'(RingDepth)) begin
              fill_q[ch_q] <= fill_q[ch_q] + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KindEmpty;
            out_chan_q  <= ch_q;
            out_raw_q   <= rd_raw_q;
            out_ring_q  <= '0;
            out_lat_q   <= rd_lat_q;
            out_pos_q   <= '0;
            out_cnt_q   <= '0;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          state_q <= ST_RING;
        end
        ST_RING: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KindRing;
            out_chan_q  <= ch_q;
            out_raw_q   <= rd_raw_q;
            out_ring_q  <= mem_rdata;
            out_lat_q   <= rd_lat_q;
            out_pos_q   <= idx_q[PosW-1:0];
            out_cnt_q   <= n_q;
            out_last_q  <= ring_last;
            if (ring_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_FETCH;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_kind_q;
  assign out_o.chan_out       = out_chan_q;
  assign out_o.raw_out        = out_raw_q;
  assign out_o.ring_value     = out_ring_q;
  assign out_o.latest_scaled  = out_lat_q;
  assign out_o.position       = out_pos_q;
  assign out_o.returned_count = out_cnt_q;
  assign out_o.last           = out_last_q;

`ifndef SYNTH
  a_done_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_done |-> state_q == ST_SCALE)
    else $error("scale unit finished outside the scale wait");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[ch_q] <= FillW'(RingDepth))
    else $error("fill count above ring depth");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH || state_q == ST_RING) |-> idx_q < n_q)
    else $error("ring walk past returned count");

  a_ring_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KindRing && out_last_q)
      |-> CntW'(out_pos_q) + 1'b1 == out_cnt_q)
    else $error("last ring value at wrong position");
`endif

endmodule
